FILE: sv/paired_program_receiver_macros.svh
// Assertion macros shared by the paired program receiver modules.
`ifndef PAIRED_PROGRAM_RECEIVER_MACROS_SVH
`define PAIRED_PROGRAM_RECEIVER_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define PRR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Trigger in one cycle implies consequence in the next.
`define PRR_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/prr_pkg.sv
// Shared types and codes for the paired program receiver.
package prr_pkg;

  // Operation codes
  localparam logic [3:0] OP_PAIR_REQ    = 4'd0;
  localparam logic [3:0] OP_UNPAIR      = 4'd1;
  localparam logic [3:0] OP_PROG_START  = 4'd2;
  localparam logic [3:0] OP_BLOCK_DATA  = 4'd3;
  localparam logic [3:0] OP_PROG_END    = 4'd4;
  localparam logic [3:0] OP_OTHER_TYPE  = 4'd5;
  localparam logic [3:0] OP_LOCAL_CLEAR = 4'd6;
  localparam logic [3:0] OP_RESTORE     = 4'd7;
  localparam logic [3:0] OP_READ_BLOCK  = 4'd8;

  // Status codes
  localparam logic [3:0] ST_IGNORED      = 4'd0;
  localparam logic [3:0] ST_PAIR_ACK     = 4'd1;
  localparam logic [3:0] ST_REM_UNPAIRED = 4'd2;
  localparam logic [3:0] ST_UNKNOWN_TYPE = 4'd3;
  localparam logic [3:0] ST_FILTERED     = 4'd4;
  localparam logic [3:0] ST_STARTED      = 4'd5;
  localparam logic [3:0] ST_STORED       = 4'd6;
  localparam logic [3:0] ST_SLOT_RANGE   = 4'd7;
  localparam logic [3:0] ST_PROG_ACK     = 4'd8;
  localparam logic [3:0] ST_DISCARDED    = 4'd9;
  localparam logic [3:0] ST_CLEARED      = 4'd10;
  localparam logic [3:0] ST_RESTORED     = 4'd11;
  localparam logic [3:0] ST_READ_DONE    = 4'd12;

  typedef struct packed {
    logic [3:0]  operation;
    logic [47:0] sender_addr;
    logic [47:0] carried_addr;
    logic        pairing_window;
    logic        length_ok;
    logic [7:0]  announced_count;
    logic [7:0]  block_slot;
    logic [63:0] block_payload;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [47:0] reply_addr;
    logic [5:0]  ack_count;
    logic        is_paired;
    logic [7:0]  received_total;
    logic [5:0]  program_length;
    logic [63:0] read_payload;
    logic        read_valid;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic copy_rd;
    logic copy_wr;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_copy;
    logic copy_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

FILE: sv/prr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/prr_ctrl.sv
// Sequencing state machine for the paired program receiver.
`include "paired_program_receiver_macros.svh"

module prr_ctrl import prr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_COPY_RD = 3'd2;
  localparam logic [2:0] S_COPY_WR = 3'd3;
  localparam logic [2:0] S_FIN     = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_copy ? S_COPY_RD : S_FIN;
      end
      S_COPY_RD: begin
        cmd.copy_rd = 1'b1;
        state_nxt   = S_COPY_WR;
      end
      S_COPY_WR: begin
        cmd.copy_wr = 1'b1;
        state_nxt   = sts.copy_last ? S_FIN : S_COPY_RD;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  `PRR_ASSERT(a_load_out_free, !cmd.load_out || sts.out_free, "result loaded over pending beat")
  `PRR_ASSERT_NEXT(a_exec_to_copy, (state_r == S_EXEC) && sts.need_copy,
                   state_r == S_COPY_RD, "commit did not start copy")

endmodule

FILE: sv/prr_datapath.sv
// Pairing state, reception counters, block stores and result register.
`include "paired_program_receiver_macros.svh"

module prr_datapath import prr_pkg::*; #(
  parameter int MAX_BLOCKS = 32,
  parameter int BLOCK_BITS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  ctrl_cmd_t cmd,
  output ctrl_sts_t sts,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  in_item_t item_r;

  logic             pair_held_r, pair_held_nxt;
  logic [47:0]      pair_addr_r, pair_addr_nxt;
  logic             receiving_r, receiving_nxt;
  logic [CNT_W-1:0] expected_r, expected_nxt;
  logic [7:0]       got_r, got_nxt;
  logic [CNT_W-1:0] committed_r, committed_nxt;

  logic [3:0]  res_status_r, res_status_nxt;
  logic [47:0] res_reply_r, res_reply_nxt;
  logic [5:0]  res_ack_r, res_ack_nxt;
  logic        res_rvalid_r, res_rvalid_nxt;

  logic [MAX_BLOCKS-1:0] rx_vld_r;
  logic [IDX_W-1:0]      idx_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  logic            rx_we_c, prog_re_c, need_copy_c, filt_c;
  logic [7:0]      exp8, comm8, capped;
  logic [IDX_W-1:0] slot_idx;
  logic [BLOCK_BITS-1:0] rx_rdata, prog_rdata, prog_wdata;

  assign exp8     = 8'(expected_r);
  assign comm8    = 8'(committed_r);
  assign slot_idx = item_r.block_slot[IDX_W-1:0];
  assign capped   = (item_r.announced_count > 8'(MAX_BLOCKS)) ? 8'(MAX_BLOCKS)
                                                              : item_r.announced_count;
  // With the window closed, only the held peer gets through
  assign filt_c = !item_r.pairing_window &&
                  (!pair_held_r || (item_r.sender_addr != pair_addr_r));

  always_comb begin
    pair_held_nxt  = pair_held_r;
    pair_addr_nxt  = pair_addr_r;
    receiving_nxt  = receiving_r;
    expected_nxt   = expected_r;
    got_nxt        = got_r;
    committed_nxt  = committed_r;
    res_status_nxt = ST_IGNORED;
    res_reply_nxt  = '0;
    res_ack_nxt    = '0;
    res_rvalid_nxt = 1'b0;
    rx_we_c        = 1'b0;
    prog_re_c      = 1'b0;
    need_copy_c    = 1'b0;
    case (item_r.operation)
      OP_PAIR_REQ: begin
        if (item_r.pairing_window && item_r.length_ok) begin
          pair_addr_nxt  = item_r.carried_addr;
          pair_held_nxt  = 1'b1;
          res_status_nxt = ST_PAIR_ACK;
          res_reply_nxt  = item_r.carried_addr;
        end
      end
      OP_UNPAIR: begin
        if (pair_held_r) begin
          if (item_r.sender_addr == pair_addr_r) begin
            pair_addr_nxt  = '0;
            pair_held_nxt  = 1'b0;
            res_status_nxt = ST_REM_UNPAIRED;
          end else begin
            res_status_nxt = ST_FILTERED;
          end
        end else begin
          res_status_nxt = filt_c ? ST_FILTERED : ST_UNKNOWN_TYPE;
        end
      end
      OP_PROG_START: begin
        if (filt_c) begin
          res_status_nxt = ST_FILTERED;
        end else if (item_r.length_ok) begin
          expected_nxt   = CNT_W'(capped);
          got_nxt        = '0;
          receiving_nxt  = 1'b1;
          res_status_nxt = ST_STARTED;
        end
      end
      OP_BLOCK_DATA: begin
        if (filt_c) begin
          res_status_nxt = ST_FILTERED;
        end else if (receiving_r && item_r.length_ok) begin
          if (item_r.block_slot < 8'(MAX_BLOCKS)) begin
            rx_we_c        = 1'b1;
            got_nxt        = (got_r != 8'hFF) ? got_r + 8'd1 : got_r;
            res_status_nxt = ST_STORED;
          end else begin
            res_status_nxt = ST_SLOT_RANGE;
          end
        end
      end
      OP_PROG_END: begin
        if (filt_c) begin
          res_status_nxt = ST_FILTERED;
        end else if (receiving_r) begin
          receiving_nxt = 1'b0;
          if (got_r >= exp8) begin
            committed_nxt  = expected_r;
            need_copy_c    = (expected_r != '0);
            res_status_nxt = ST_PROG_ACK;
            res_reply_nxt  = item_r.sender_addr;
            res_ack_nxt    = exp8[5:0];
          end else begin
            res_status_nxt = ST_DISCARDED;
          end
        end
      end
      OP_OTHER_TYPE: begin
        res_status_nxt = filt_c ? ST_FILTERED : ST_UNKNOWN_TYPE;
      end
      OP_LOCAL_CLEAR: begin
        pair_addr_nxt  = '0;
        pair_held_nxt  = 1'b0;
        res_status_nxt = ST_CLEARED;
      end
      OP_RESTORE: begin
        pair_addr_nxt  = item_r.carried_addr;
        pair_held_nxt  = 1'b1;
        res_status_nxt = ST_RESTORED;
      end
      OP_READ_BLOCK: begin
        if ((item_r.block_slot < comm8) && (item_r.block_slot < 8'(MAX_BLOCKS))) begin
          prog_re_c      = 1'b1;
          res_rvalid_nxt = 1'b1;
        end
        res_status_nxt = ST_READ_DONE;
      end
      default: begin
        res_status_nxt = ST_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.exec) begin
      res_status_r <= res_status_nxt;
      res_reply_r  <= res_reply_nxt;
      res_ack_r    <= res_ack_nxt;
      res_rvalid_r <= res_rvalid_nxt;
    end
    if (cmd.load_out) begin
      out_data_r.status         <= res_status_r;
      out_data_r.reply_addr     <= res_reply_r;
      out_data_r.ack_count      <= res_ack_r;
      out_data_r.is_paired      <= pair_held_r;
      out_data_r.received_total <= got_r;
      out_data_r.program_length <= comm8[5:0];
      out_data_r.read_payload   <= res_rvalid_r ? 64'(prog_rdata) : 64'd0;
      out_data_r.read_valid     <= res_rvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_held_r <= 1'b0;
      pair_addr_r <= '0;
      receiving_r <= 1'b0;
      expected_r  <= '0;
      got_r       <= '0;
      committed_r <= '0;
      rx_vld_r    <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        pair_held_r <= pair_held_nxt;
        pair_addr_r <= pair_addr_nxt;
        receiving_r <= receiving_nxt;
        expected_r  <= expected_nxt;
        got_r       <= got_nxt;
        committed_r <= committed_nxt;
        idx_r       <= '0;
        if (rx_we_c) begin
          rx_vld_r[slot_idx] <= 1'b1;
        end
      end else if (cmd.copy_wr) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // never-written receive entries copy as zero
  assign prog_wdata = rx_vld_r[idx_r] ? rx_rdata : '0;

  prr_ram #(.WIDTH(BLOCK_BITS), .DEPTH(MAX_BLOCKS)) u_rx_ram (
    .clk   (clk),
    .we    (cmd.exec && rx_we_c),
    .waddr (slot_idx),
    .wdata (item_r.block_payload[BLOCK_BITS-1:0]),
    .re    (cmd.copy_rd),
    .raddr (idx_r),
    .rdata (rx_rdata)
  );

  prr_ram #(.WIDTH(BLOCK_BITS), .DEPTH(MAX_BLOCKS)) u_prog_ram (
    .clk   (clk),
    .we    (cmd.copy_wr),
    .waddr (idx_r),
    .wdata (prog_wdata),
    .re    (cmd.exec && prog_re_c),
    .raddr (slot_idx),
    .rdata (prog_rdata)
  );

  assign sts.need_copy = need_copy_c;
  assign sts.copy_last = ((CNT_W'(idx_r) + CNT_W'(1)) == expected_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PRR_ASSERT(a_copy_in_range, !cmd.copy_wr || (CNT_W'(idx_r) < expected_r),
              "copy index past expected count")
  `PRR_ASSERT(a_expected_cap, expected_r <= CNT_W'(MAX_BLOCKS), "expected count over cap")
  `PRR_ASSERT_NEXT(a_load_shows, cmd.load_out, out_valid_r, "loaded result not presented")

endmodule

FILE: sv/paired_program_receiver.sv
// Top level of the paired program receiver: controller plus datapath.
//
// Takes one decoded radio message per input beat and returns exactly one
// result beat for it. An item is accepted, executed and then presented as
// a result; a program end that commits blocks also runs a copy loop, since
// the commit copies the receive store into the program store one block at
// a time through the receive RAM's single registered read port.
// One item is in work at a time, but a new item is taken while the
// previous result still waits in the output register. Both block stores
// read as zero after reset: the receive store has one valid bit per entry,
// and the program store is only read below the committed length, which is
// always fully written by a commit. No clearing pass runs after reset.
// Block payloads keep their low BLOCK_BITS bits; read_payload is
// zero-extended back to 64 bits.
`include "paired_program_receiver_macros.svh"

module paired_program_receiver import prr_pkg::*; #(
  parameter int MAX_BLOCKS = 32,  // store depth and announced count cap, 1..255
  parameter int BLOCK_BITS = 64   // bits kept per block, 8..64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ctrl_cmd_t cmd;  // controller commands
  ctrl_sts_t sts;  // datapath status

  // Controller: accept, execute, copy loop, result hand-off.
  prr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: pairing and reception state, two block RAMs, result register.
  prr_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .BLOCK_BITS (BLOCK_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // An input beat is only taken while no item is in work.
  `PRR_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall, "accepted beat left block idle")

endmodule
